### src/mlds_pkg.sv
// Shared types and constants of the ML direction-of-arrival spectrum block.
`timescale 1ns / 1ps
package mlds_pkg;

	localparam int unsigned ACC_W    = 36;
	localparam int unsigned ENERGY_W = 35;
	localparam int unsigned VALUE_W  = 16;
	localparam logic [31:0] LN2_Q32  = 32'd2977044472;

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ACC,
		ST_BACK,
		ST_OUT
	} top_state_t;

	typedef enum logic [3:0] {
		BE_IDLE,
		BE_SQA,
		BE_SQB,
		BE_ADD,
		BE_CMP,
		BE_DIV,
		BE_SQRT,
		BE_NORM,
		BE_LOG,
		BE_SCALE,
		BE_ROUND,
		BE_DONE
	} be_state_t;

	typedef struct packed {
		logic                       start;
		logic signed [ACC_W-1:0]    acc_re;
		logic signed [ACC_W-1:0]    acc_im;
		logic [ENERGY_W-1:0]        energy;
	} be_req_t;

	typedef struct packed {
		logic               done;
		logic               sat;
		logic [VALUE_W-1:0] value;
	} be_rsp_t;

endpackage

### src/ml_doa_spectrum_bin.sv
// Top level: ML direction-of-arrival spectrum value for one bin of a mic array.
// A load request writes the coefficient memory; a sample request reads it and
// accumulates, and a sample on the last channel in use yields a result through
// the back end (32-step ratio division, 16-step square root and 16 squaring
// rounds of the log), which skips those steps when the value saturates. It takes
// one request at a time, and a new one only once idle again. Reset: arst_n clears
// control, accumulators and channels_in_use (8); memory holds.
`timescale 1ns / 1ps
module ml_doa_spectrum_bin
	import mlds_pkg::*;
#(
	parameter int unsigned MAX_CHANNELS = 8,
	parameter int unsigned BINS         = 256,
	parameter int unsigned ANGLES       = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// angle_index[4:0], bin_index[12:5], channel_index[15:13], coef_re[31:16],
	// coef_im[47:32], sample_re[63:48], sample_im[79:64], frame_energy[114:80]
	input  logic [119:0] s_tdata,
	input  logic         s_tuser,   // req_type
	output logic         m_tvalid,
	input  logic         m_tready,
	// spectrum_value[15:0], angle_out[20:16], bin_out[28:21]
	output logic [31:0]  m_tdata,
	output logic         m_tuser,   // saturated
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [3:0]   cfg_data   // channels_in_use
);

	localparam int unsigned DEPTH = ANGLES * BINS * MAX_CHANNELS;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	top_state_t state_q, state_d;

	// unpack the request
	logic [4:0]  in_ang;
	logic [7:0]  in_bin;
	logic [2:0]  in_ch;
	logic [31:0] in_coef;
	logic [31:0] addr_full;
	logic        addr_ok;
	logic        accept;

	assign in_ang  = s_tdata[4:0];
	assign in_bin  = s_tdata[12:5];
	assign in_ch   = s_tdata[15:13];
	assign in_coef = s_tdata[47:16];
	assign accept  = s_tvalid && s_tready;

	assign addr_full = (32'(in_ang) * 32'(BINS) + 32'(in_bin)) * 32'(MAX_CHANNELS)
		+ 32'(in_ch);
	assign addr_ok = (32'(in_ang) < 32'(ANGLES)) && (32'(in_bin) < 32'(BINS))
		&& (32'(in_ch) < 32'(MAX_CHANNELS));

	logic [31:0] coef_rdata;

	// drop loads outside the table; samples there read a zero coefficient
	mlds_coef_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_coef_ram (
		.clk  (clk),
		.we   (accept && (s_tuser == REQ_LOAD) && addr_ok),
		.waddr(addr_full[AW-1:0]),
		.wdata(in_coef),
		.re   (accept && (s_tuser == REQ_SAMPLE)),
		.raddr(addr_full[AW-1:0]),
		.rdata(coef_rdata)
	);

	// sample request held through the multiply-accumulate
	logic signed [15:0]  smp_re_q, smp_im_q;
	logic [ENERGY_W-1:0] energy_q;
	logic [4:0]          ang_q;
	logic [7:0]          bin_q;
	logic [2:0]          ch_q;
	logic                aok_q;
	logic [3:0]          chan_cfg_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_re_q <= s_tdata[63:48];
			smp_im_q <= s_tdata[79:64];
			energy_q <= s_tdata[114:80];
			ang_q    <= in_ang;
			bin_q    <= in_bin;
			ch_q     <= in_ch;
			aok_q    <= addr_ok;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cfg_q <= 4'd8;
		end else if (cfg_valid && cfg_ready) begin
			chan_cfg_q <= cfg_data;
		end
	end

	// zero acts as one channel, anything above MAX_CHANNELS as MAX_CHANNELS
	logic [3:0] last_ch;
	logic       is_last;

	always_comb begin
		if (chan_cfg_q == 4'd0) begin
			last_ch = 4'd0;
		end else if (32'(chan_cfg_q) > 32'(MAX_CHANNELS)) begin
			last_ch = 4'(MAX_CHANNELS - 1);
		end else begin
			last_ch = chan_cfg_q - 4'd1;
		end
	end
	assign is_last = ({1'b0, ch_q} == last_ch);

	// conjugate products, one register stage before the accumulate
	logic signed [15:0] c_re, c_im;
	logic signed [31:0] p_rr_s1, p_ii_s1, p_ir_s1, p_ri_s1;

	assign c_re = aok_q ? coef_rdata[15:0]  : 16'sd0;
	assign c_im = aok_q ? coef_rdata[31:16] : 16'sd0;

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			p_rr_s1 <= smp_re_q * c_re;
			p_ii_s1 <= smp_im_q * c_im;
			p_ir_s1 <= smp_im_q * c_re;
			p_ri_s1 <= smp_re_q * c_im;
		end
	end

	// accumulators wrap at 36 bits; channel 0 restarts the sum
	logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
	logic signed [ACC_W-1:0] acc_re_base, acc_im_base;
	logic signed [ACC_W-1:0] acc_re_d, acc_im_d;

	assign acc_re_base = (ch_q == 3'd0) ? '0 : acc_re_q;
	assign acc_im_base = (ch_q == 3'd0) ? '0 : acc_im_q;
	assign acc_re_d    = acc_re_base + ACC_W'(p_rr_s1) + ACC_W'(p_ii_s1);
	assign acc_im_d    = acc_im_base + ACC_W'(p_ir_s1) - ACC_W'(p_ri_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (state_q == ST_ACC) begin
			acc_re_q <= acc_re_d;
			acc_im_q <= acc_im_d;
		end
	end

	be_req_t be_req;
	be_rsp_t be_rsp;

	// hand the back end the sum that includes this request
	assign be_req.acc_re = acc_re_d;
	assign be_req.acc_im = acc_im_d;
	assign be_req.energy = energy_q;
	assign be_req.start  = (state_q == ST_ACC) && is_last;

	mlds_backend u_backend (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (be_req),
		.rsp   (be_rsp)
	);

	logic out_free;
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (s_tuser == REQ_SAMPLE)) state_d = ST_READ;
			end
			ST_READ: state_d = ST_ACC;
			ST_ACC:  state_d = is_last ? ST_BACK : ST_IDLE;
			ST_BACK: if (be_rsp.done) state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output register: hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			m_tdata <= {3'd0, bin_q, ang_q, be_rsp.value};
			m_tuser <= be_rsp.sat;
		end
	end

endmodule

### src/mlds_coef_ram.sv
// Steering coefficient memory: one write port, one registered read port.
`timescale 1ns / 1ps
module mlds_coef_ram #(
	parameter int unsigned DEPTH = 65536,
	parameter int unsigned AW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/mlds_backend.sv
// Back end: |sum|^2, ratio division, square root, log2 and ln scaling.
`timescale 1ns / 1ps
module mlds_backend
	import mlds_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  be_req_t req,
	output be_rsp_t rsp
);

	be_state_t state_q, state_d;

	logic [31:0]         a_q, b_q;
	logic [ENERGY_W-1:0] energy_q;
	logic [63:0]         prod_q;
	logic [65:0]         m2_q;
	logic [ENERGY_W-1:0] rem_q;
	logic [31:0]         num_q;
	logic [31:0]         quo_q;
	logic [31:0]         x_q, r_q, bit_q;
	logic [16:0]         m_q;
	logic [4:0]          n_q;
	logic [15:0]         frac_q;
	logic [4:0]          cnt_q;
	logic                sat_q;
	logic [VALUE_W-1:0]  value_q;

	logic [31:0] mul_x, mul_y;
	logic [63:0] mul_p;
	logic [ACC_W-1:0] abs_re, abs_im;
	logic [ENERGY_W:0] div_r2;
	logic [31:0] sq_t;
	logic [16:0] d_val;
	logic [4:0]  d_n;
	logic [17:0] lg_mm;
	logic [20:0] neg_lg;
	logic [63:0] rnd_sum;
	logic        over;

	// shared multiplier
	always_comb begin
		mul_x = a_q;
		mul_y = a_q;
		unique case (state_q)
			BE_SQB:   begin mul_x = b_q; mul_y = b_q; end
			BE_LOG:   begin mul_x = {15'd0, m_q}; mul_y = {15'd0, m_q}; end
			BE_SCALE: begin mul_x = {11'd0, neg_lg}; mul_y = LN2_Q32; end
			default:  begin mul_x = a_q; mul_y = a_q; end
		endcase
	end
	assign mul_p = mul_x * mul_y;

	assign abs_re = req.acc_re[ACC_W-1] ? ACC_W'(-req.acc_re) : ACC_W'(req.acc_re);
	assign abs_im = req.acc_im[ACC_W-1] ? ACC_W'(-req.acc_im) : ACC_W'(req.acc_im);

	assign over = (energy_q == '0) || (m2_q >= {9'd0, energy_q, 22'd0});
	assign div_r2 = {rem_q, num_q[31]};
	assign sq_t = r_q + bit_q;
	assign d_val = 17'd65536 - {1'b0, r_q[15:0]};
	assign lg_mm = mul_p[33:16];
	assign neg_lg = 21'd1048576 - {n_q, frac_q};
	assign rnd_sum = prod_q + 64'd34359738368;

	always_comb begin
		d_n = '0;
		for (int i = 0; i < 17; i++) begin
			if (d_val[i]) begin
				d_n = 5'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BE_IDLE:  if (req.start) state_d = BE_SQA;
			BE_SQA:   state_d = BE_SQB;
			BE_SQB:   state_d = BE_ADD;
			BE_ADD:   state_d = BE_CMP;
			BE_CMP:   state_d = over ? BE_DONE : BE_DIV;
			BE_DIV:   if (cnt_q == 5'd0) state_d = BE_SQRT;
			BE_SQRT:  if (cnt_q == 5'd0) state_d = BE_NORM;
			BE_NORM:  state_d = BE_LOG;
			BE_LOG:   if (cnt_q == 5'd0) state_d = BE_SCALE;
			BE_SCALE: state_d = BE_ROUND;
			BE_ROUND: state_d = BE_DONE;
			BE_DONE:  state_d = BE_IDLE;
			default:  state_d = BE_IDLE;
		endcase
	end

	always_comb begin
		rsp.done  = (state_q == BE_DONE);
		rsp.sat   = sat_q;
		rsp.value = value_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BE_IDLE: begin
				a_q      <= abs_re[35:4];
				b_q      <= abs_im[35:4];
				energy_q <= req.energy;
			end
			BE_SQA: prod_q <= mul_p;
			BE_SQB: begin
				m2_q   <= {2'd0, prod_q};
				prod_q <= mul_p;
			end
			BE_ADD: m2_q <= m2_q + {2'd0, prod_q};
			BE_CMP: begin
				sat_q   <= over;
				value_q <= '1;
				rem_q   <= m2_q[56:22];
				num_q   <= {m2_q[21:0], 10'd0};
				cnt_q   <= 5'd31;
			end
			BE_DIV: begin
				// one quotient bit per cycle
				if (div_r2 >= {1'b0, energy_q}) begin
					rem_q <= ENERGY_W'(div_r2 - {1'b0, energy_q});
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= div_r2[ENERGY_W-1:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
				num_q <= {num_q[30:0], 1'b0};
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					x_q   <= {quo_q[30:0], div_r2 >= {1'b0, energy_q}};
					r_q   <= '0;
					bit_q <= 32'h4000_0000;
					cnt_q <= 5'd15;
				end
			end
			BE_SQRT: begin
				if (x_q >= sq_t) begin
					x_q <= x_q - sq_t;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q - 5'd1;
			end
			BE_NORM: begin
				n_q    <= d_n;
				m_q    <= 17'(d_val << (5'd16 - d_n));
				frac_q <= '0;
				cnt_q  <= 5'd15;
			end
			BE_LOG: begin
				// square and pull out one fraction bit
				if (lg_mm[17]) begin
					m_q    <= lg_mm[17:1];
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					m_q    <= lg_mm[16:0];
					frac_q <= {frac_q[14:0], 1'b0};
				end
				cnt_q <= cnt_q - 5'd1;
			end
			BE_SCALE: prod_q <= mul_p;
			BE_ROUND: value_q <= (rnd_sum[63:52] != '0) ? '1 : rnd_sum[51:36];
			default: ;
		endcase
	end

endmodule

### dv/tb_ml_doa_spectrum_bin.sv
// Self-checking testbench for the ML direction-of-arrival spectrum bin block.
`timescale 1ns / 1ps
module tb_ml_doa_spectrum_bin;
	import mlds_pkg::*;

	localparam int          NCH        = 8;
	localparam longint      CYCLE_CAP  = 2000000;
	localparam int          DRAIN_WAIT = 100;    // margin for the back end to finish
	localparam bit [34:0]   ENERGY_MAX = 35'h4_0000_0000;

	// one request on the input stream
	typedef struct {
		logic             kind;
		bit [4:0]         ang;
		bit [7:0]         bin;
		bit [2:0]         ch;
		bit signed [15:0] cre, cim, sre, sim;
		bit [34:0]        energy;
	} bin_req_t;

	// one spectrum result
	typedef struct {
		bit [15:0] value;
		bit        sat;
		bit [4:0]  ang;
		bit [7:0]  bin;
	} spec_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [119:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [31:0]  m_tdata;
	logic         m_tuser;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [3:0]   cfg_data = 4'd0;

	// model state: coefficient table, accumulators, channel count
	bit [31:0]        coef_mem [int];
	bit signed [35:0] sum_re, sum_im;
	bit [3:0]         chan_reg;

	spec_t     pending_bins [$];
	bit [12:0] loaded_pairs [$];   // {angle, bin} with all channels written
	int        errors = 0;
	bit        gaps_on = 1'b1;
	bit        hold_req = 1'b0;
	longint    cycles = 0;

	ml_doa_spectrum_bin uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic bit [31:0] int_root(bit [31:0] x);
		bit [31:0] r, b;
		r = 0;
		b = 32'h4000_0000;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// log2 with 16 fraction bits, by normalize and repeated squaring
	function automatic bit [31:0] log2_frac16(bit [31:0] d);
		bit [31:0] n, frac;
		bit [63:0] m;
		n = 0;
		frac = 0;
		while (n < 16 && (d >> (n + 1)) != 0) n++;
		m = 64'(d) << (16 - n);
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 16;
			frac = frac << 1;
			if (m >= 64'h2_0000) begin
				frac[0] = 1'b1;
				m = m >> 1;
			end
		end
		return (n << 16) | frac;
	endfunction

	function automatic bit [63:0] mag4(bit signed [35:0] v);
		bit [35:0] a;
		a = v[35] ? 36'(-v) : 36'(v);
		return 64'(a >> 4);
	endfunction

	// Advance the model by one accepted request; queue a result on the last channel.
	function automatic void spectrum_pred(bin_req_t r);
		int               key;
		bit [31:0]        c;
		bit signed [15:0] cr, ci;
		longint           pr, pi;
		int               last_ch;
		bit [63:0]        a, b, m2, en, q, val;
		bit [31:0]        s, neg;
		spec_t            e;
		key = {r.ang, r.bin, r.ch};
		if (r.kind == REQ_LOAD) begin
			coef_mem[key] = {r.cim, r.cre};
			return;
		end
		c = coef_mem.exists(key) ? coef_mem[key] : 32'd0;
		cr = c[15:0];
		ci = c[31:16];
		pr = longint'(r.sre) * cr + longint'(r.sim) * ci;
		pi = longint'(r.sim) * cr - longint'(r.sre) * ci;
		if (r.ch == 0) begin
			sum_re = 36'(pr);
			sum_im = 36'(pi);
		end else begin
			sum_re = sum_re + 36'(pr);
			sum_im = sum_im + 36'(pi);
		end
		last_ch = (chan_reg == 0) ? 0 : (chan_reg > NCH) ? NCH - 1 : chan_reg - 1;
		if (r.ch != last_ch) return;
		a = mag4(sum_re);
		b = mag4(sum_im);
		m2 = a * a + b * b;
		en = 64'(r.energy);
		if (en == 0 || m2 >= (en << 22)) begin
			e.sat = 1'b1;
			e.value = 16'hFFFF;
		end else begin
			e.sat = 1'b0;
			q = ((m2 / en) << 10) + (((m2 % en) << 10) / en);
			s = int_root(q[31:0]);
			neg = (32'd16 << 16) - log2_frac16(32'd65536 - s);
			val = (64'(neg) * 64'(LN2_Q32) + (64'd1 << 35)) >> 36;
			e.value = (val > 65535) ? 16'hFFFF : val[15:0];
		end
		e.ang = r.ang;
		e.bin = r.bin;
		pending_bins.push_back(e);
	endfunction

	// Offer one request; hold valid until accepted, then maybe idle.
	// Call right after a rising edge.
	task automatic send_req(bin_req_t r);
		s_tvalid <= 1'b1;
		s_tuser <= r.kind;
		s_tdata <= {5'd0, r.energy, r.sim, r.sre, r.cim, r.cre, r.ch, r.bin, r.ang};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		spectrum_pred(r);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// Drain outstanding results, then write channels_in_use.
	task automatic write_channels(bit [3:0] v);
		s_tvalid <= 1'b0;
		while (pending_bins.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		chan_reg = v;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic bit signed [15:0] rand_q15();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return -16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Write a full steering vector for one angle/bin pair.
	task automatic load_pair(bit [4:0] ang, bit [7:0] bin);
		bin_req_t r;
		for (int ch = 0; ch < NCH; ch++) begin
			r = '{REQ_LOAD, ang, bin, 3'(ch), rand_q15(), rand_q15(), 16'($urandom),
				16'($urandom), 35'({$urandom, $urandom})};
			send_req(r);
		end
		loaded_pairs.push_back({ang, bin});
	endtask

	function automatic bit [34:0] pick_energy(bit [34:0] true_e, int mode);
		bit [63:0] e;
		case (mode)
			0: return 35'd0;
			1: return ENERGY_MAX;
			2: return 35'd1;
			3: begin
				e = {$urandom, $urandom} & 64'h7_FFFF_FFFF;
				return (e > ENERGY_MAX) ? ENERGY_MAX : e[34:0];
			end
			default: begin
				e = 64'(true_e) * $urandom_range(1, 16);
				return (e > ENERGY_MAX) ? ENERGY_MAX : e[34:0];
			end
		endcase
	endfunction

	// Send samples for channels 0..n-1 of one loaded pair; mode picks the energy.
	task automatic send_sum(int n, int mode);
		bin_req_t  r;
		bit [12:0] p;
		bit [34:0] tot;
		p = loaded_pairs[$urandom_range(0, loaded_pairs.size() - 1)];
		tot = 0;
		for (int ch = 0; ch < n; ch++) begin
			r.kind = REQ_SAMPLE;
			{r.ang, r.bin} = p;
			r.ch = 3'(ch);
			r.cre = 16'($urandom);
			r.cim = 16'($urandom);
			r.sre = rand_q15();
			r.sim = rand_q15();
			tot = tot + 35'(int'(r.sre) * r.sre) + 35'(int'(r.sim) * r.sim);
			r.energy = (ch == n - 1) ? pick_energy(tot, mode)
				: 35'({$urandom, $urandom});
			send_req(r);
		end
	endtask

	function automatic int eff_channels();
		return (chan_reg == 0) ? 1 : (chan_reg > NCH) ? NCH : chan_reg;
	endfunction

	// Receiver: check accepted results and idle at random.
	initial begin
		int hold_cnt;
		spec_t e;
		hold_cnt = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_bins.size() == 0) begin
					errors++;
					$display("%0t: unexpected result %h sat %b", $time, m_tdata, m_tuser);
				end else begin
					e = pending_bins.pop_front();
					if (m_tdata[15:0] !== e.value || m_tuser !== e.sat
						|| m_tdata[20:16] !== e.ang || m_tdata[28:21] !== e.bin) begin
						errors++;
						$display("%0t: mismatch expected value %h sat %b ang %0d bin %0d,",
							$time, e.value, e.sat, e.ang, e.bin,
							" actual value %h sat %b ang %0d bin %0d",
							m_tdata[15:0], m_tuser, m_tdata[20:16], m_tdata[28:21]);
					end
				end
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = 400;
				m_tready <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				hold_cnt = $urandom_range(0, 14);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Default channel count, extreme coefficients and samples, special energies.
	task automatic test_directed();
		bin_req_t r;
		load_pair(5'd0, 8'd0);
		send_sum(eff_channels(), 4);
		write_channels(4'd1);
		loaded_pairs.delete();
		for (int ch = 0; ch < NCH; ch++) begin
			r = '{REQ_LOAD, 5'd31, 8'd255, 3'(ch), 16'sh7FFF, -16'sh8000, 16'sd0, 16'sd0,
				35'd0};
			send_req(r);
		end
		loaded_pairs.push_back({5'd31, 8'd255});
		for (int mode = 0; mode < 5; mode++) send_sum(1, mode);
		r = '{REQ_SAMPLE, 5'd31, 8'd255, 3'd0, 16'sd0, 16'sd0, -16'sh8000, -16'sh8000,
			ENERGY_MAX};
		send_req(r);
		r = '{REQ_SAMPLE, 5'd31, 8'd255, 3'd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh0001,
			35'd2147418113};
		send_req(r);
	endtask

	// Settings 0, 15, 9, 8, 3 and 2, out-of-range counts among them.
	task automatic test_channel_counts();
		bit [3:0] vals [6] = '{4'd0, 4'd15, 4'd9, 4'd8, 4'd3, 4'd2};
		load_pair(5'($urandom), 8'($urandom));
		foreach (vals[i]) begin
			write_channels(vals[i]);
			repeat (3) send_sum(eff_channels(), $urandom_range(0, 8));
		end
	endtask

	// Mixed addresses within a sum, and channels added without a restart.
	task automatic test_mixed();
		bin_req_t  r;
		bit [12:0] p;
		write_channels(4'd4);
		load_pair(5'($urandom), 8'($urandom));
		for (int i = 0; i < 12; i++) begin
			p = loaded_pairs[$urandom_range(0, loaded_pairs.size() - 1)];
			r.kind = REQ_SAMPLE;
			{r.ang, r.bin} = p;
			r.ch = (i < 4) ? 3'(i) : 3'($urandom_range(1, 7));
			r.cre = '0;
			r.cim = '0;
			r.sre = 16'($urandom);
			r.sim = 16'($urandom);
			r.energy = pick_energy(35'h1_0000_0000, $urandom_range(0, 8));
			send_req(r);
		end
	endtask

	// Long receiver hold-off while requests keep coming.
	task automatic test_backpressure();
		write_channels(4'd2);
		hold_req = 1'b1;
		repeat (10) send_sum(2, 4);
	endtask

	// Random mix: mostly well-formed sums, some loads and stray samples.
	task automatic test_random();
		bin_req_t r;
		int       sent;
		bit [12:0] p;
		sent = 0;
		while (sent < 450) begin
			if (sent > 370) gaps_on = 1'b0;
			case ($urandom_range(0, 19))
				0: begin
					write_channels(4'($urandom_range(0, 15)));
				end
				1: begin
					load_pair(5'($urandom), 8'($urandom));
					sent += NCH;
				end
				2, 3: begin
					p = loaded_pairs[$urandom_range(0, loaded_pairs.size() - 1)];
					r.kind = REQ_SAMPLE;
					{r.ang, r.bin} = p;
					r.ch = 3'($urandom);
					r.cre = 16'($urandom);
					r.cim = 16'($urandom);
					r.sre = rand_q15();
					r.sim = rand_q15();
					r.energy = pick_energy(35'({$urandom, $urandom}),
						$urandom_range(0, 8));
					send_req(r);
					sent++;
				end
				default: begin
					send_sum(eff_channels(), $urandom_range(0, 10));
					sent += eff_channels();
				end
			endcase
		end
	endtask

	initial begin
		sum_re = 0;
		sum_im = 0;
		chan_reg = 4'd8;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_channel_counts();
		test_mixed();
		test_backpressure();
		test_random();
		s_tvalid <= 1'b0;
		while (pending_bins.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
